// ----- rtl/core/amde_pkg.sv -----
// Shared constants, status type and arctangent table for the affine matrix
// decomposition unit. No dependencies.
package amde_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int WORD_W           = 32;
  localparam int SCALE_W          = 31;
  localparam int RAD_W            = 64;
  localparam int ZW               = 34;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      5'd24: v = 30'h0000003F;
      5'd25: v = 30'h0000001F;
      5'd26: v = 30'h0000000F;
      5'd27: v = 30'h00000008;
      5'd28: v = 30'h00000004;
      5'd29: v = 30'h00000002;
      5'd30: v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/amde_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on amde_pkg.
module amde_mul import amde_pkg::*; #(
  parameter int W = WORD_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  output logic [2*W-1:0] prod,
  output unit_sts_t      sts
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  mcand;
  logic [W-1:0]  lo;
  logic [W:0]    hi;
  logic [W:0]    sum;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  assign sum = lo[0] ? hi + {1'b0, mcand} : hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= a;
    end else if (busy) begin
      hi <= {1'b0, sum[W:1]};
      lo <= {sum[0], lo[W-1:1]};
    end
  end

  assign prod     = {hi[W-1:0], lo};
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ----- rtl/core/amde_sqrt.sv -----
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on amde_pkg.
module amde_sqrt import amde_pkg::*; #(
  parameter int W = RAD_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   rad_in,
  output logic [W/2-1:0] root,
  output unit_sts_t      sts
);
  localparam int H  = W / 2;
  localparam int CW = $clog2(H + 1);

  logic [W-1:0]  rad;
  logic [H:0]    rem;
  logic [H+2:0]  remsh;
  logic [H+2:0]  trial;
  logic [H+2:0]  diff;
  logic          ge;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  assign remsh = {rem, rad[W-1:W-2]};
  assign trial = {1'b0, root, 2'b01};
  assign ge    = remsh >= trial;
  assign diff  = remsh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(H);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= rad_in;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[W-3:0], 2'b00};
      rem  <= ge ? diff[H:0] : remsh[H:0];
      root <= {root[H-2:0], ge};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ----- rtl/core/amde_div.sv -----
// Restoring divider giving one quotient bit per cycle of (num << FRAC_BITS) / den,
// for num not above den. Depends on amde_pkg.
module amde_div import amde_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WORD_W-1:0]  num,
  input  logic [WORD_W-1:0]  den,
  output logic [FRAC_BITS:0] quo,
  output unit_sts_t          sts
);
  localparam int CW = $clog2(FRAC_BITS + 2);

  logic [WORD_W-1:0] dv;
  logic [WORD_W:0]   r;
  logic [WORD_W:0]   rs;
  logic              ge;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              done;

  assign ge = r >= {1'b0, dv};
  assign rs = ge ? r - {1'b0, dv} : r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(FRAC_BITS + 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= den;
      r   <= {1'b0, num};
      quo <= '0;
    end else if (busy) begin
      r   <= {rs[WORD_W-1:0], 1'b0};
      quo <= {quo[FRAC_BITS-1:0], ge};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ----- rtl/core/amde_cordic.sv -----
// Vectoring CORDIC arctangent of (y, x), one iteration per cycle, Q30 angle.
// Depends on amde_pkg.
module amde_cordic import amde_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [FRAC_BITS+1:0] y_in,
  input  logic signed [FRAC_BITS+1:0] x_in,
  output logic signed [ZW-1:0]      angle,
  output unit_sts_t                 sts
);
  localparam int NW = FRAC_BITS + 2;
  localparam int XW = FRAC_BITS + 4;
  localparam int IW = $clog2(CORDIC_STEPS);

  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [XW-1:0] xe;
  logic signed [XW-1:0] ye;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] z;
  logic signed [ZW-1:0] step_a;
  logic [IW-1:0]        idx;
  logic                 busy;
  logic                 done;
  logic                 special;

  assign xe      = XW'(x_in);
  assign ye      = XW'(y_in);
  assign dx      = y >>> idx;
  assign dy      = x >>> idx;
  assign step_a  = $signed({{(ZW-30){1'b0}}, atan_q30(5'(idx))});
  assign special = (y_in == '0) || (x_in == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (special) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && idx == IW'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx <= '0;
      x   <= xe;
      y   <= ye;
      if (y_in == '0) begin
        z <= x_in[NW-1] ? PI_Q30 : '0;
      end else if (x_in == '0) begin
        z <= y_in[NW-1] ? -HALF_PI_Q30 : HALF_PI_Q30;
      end else if (x_in[NW-1]) begin
        if (!y_in[NW-1]) begin
          x <= ye;
          y <= -xe;
          z <= HALF_PI_Q30;
        end else begin
          x <= -ye;
          y <= xe;
          z <= -HALF_PI_Q30;
        end
      end else begin
        z <= '0;
      end
    end else if (busy) begin
      idx <= idx + 1'b1;
      if (!y[XW-1] && y != '0) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + step_a;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - step_a;
      end
    end
  end

  assign angle    = (z > PI_Q30) ? PI_Q30 : ((z < -PI_Q30) ? -PI_Q30 : z);
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ----- rtl/core/affine_matrix_decompose_euler_unit.sv -----
// Column 0..2 words are stored when taken. A column 3 word starts the decomposition, and
// out_valid follows once the bit-serial multiplier, root, divider and CORDIC have run,
// in that order (in the gimbal case the multiply and root for the Y angle are skipped and
// CORDIC runs once); with zero w the unit goes straight to its output state.
// One matrix at a time; the next word waits until the result is in the output register.
// Synchronous reset clears control; the column store is undefined until written.
module affine_matrix_decompose_euler_unit import amde_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  column_index,
  input  logic signed [WORD_W-1:0]    col_x,
  input  logic signed [WORD_W-1:0]    col_y,
  input  logic signed [WORD_W-1:0]    col_z,
  input  logic signed [WORD_W-1:0]    col_w,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_W-1:0]    trans_x,
  output logic signed [WORD_W-1:0]    trans_y,
  output logic signed [WORD_W-1:0]    trans_z,
  output logic [SCALE_W-1:0]          scale_x,
  output logic [SCALE_W-1:0]          scale_y,
  output logic [SCALE_W-1:0]          scale_z,
  output logic signed [FRAC_BITS+2:0] angle_x,
  output logic signed [FRAC_BITS+1:0] angle_y,
  output logic signed [FRAC_BITS+2:0] angle_z,
  output logic                        degenerate
);
  localparam int NW = FRAC_BITS + 2;
  localparam int AW = FRAC_BITS + 3;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [ZW:0]    HALF   = 35'sd1 <<< (SH - 1);
  localparam logic signed [ZW:0]    LIM    = (35'(PI_Q30) + HALF) >>> SH;
  localparam logic signed [NW-1:0]  ONE_Q  = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [NW-1:0]  NEG_ONE = -ONE_Q;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_LOAD    = 4'd1;
  localparam logic [3:0] ST_SQ_GO   = 4'd2;
  localparam logic [3:0] ST_SQ_WAIT = 4'd3;
  localparam logic [3:0] ST_RT_GO   = 4'd4;
  localparam logic [3:0] ST_RT_WAIT = 4'd5;
  localparam logic [3:0] ST_DV_GO   = 4'd6;
  localparam logic [3:0] ST_DV_WAIT = 4'd7;
  localparam logic [3:0] ST_TS_GO   = 4'd8;
  localparam logic [3:0] ST_TS_WAIT = 4'd9;
  localparam logic [3:0] ST_TR_GO   = 4'd10;
  localparam logic [3:0] ST_TR_WAIT = 4'd11;
  localparam logic [3:0] ST_CR_GO   = 4'd12;
  localparam logic [3:0] ST_CR_WAIT = 4'd13;
  localparam logic [3:0] ST_OUT     = 4'd14;

  localparam logic [1:0] ANG_X = 2'd0;
  localparam logic [1:0] ANG_Y = 2'd1;

  function automatic logic signed [AW-1:0] q30_to_q(input logic signed [ZW-1:0] zq);
    logic signed [ZW:0] r;
    r = (35'(zq) + HALF) >>> SH;
    if (r > LIM) begin
      r = LIM;
    end else if (r < -LIM) begin
      r = -LIM;
    end
    return AW'(r);
  endfunction

  logic [3*WORD_W-1:0]  basis [0:2];
  logic [3*WORD_W-1:0]  row_q;
  logic [3:0]           state;
  logic [1:0]           col_cnt;
  logic [1:0]           elem_cnt;
  logic [1:0]           ang_cnt;
  logic                 deg;
  logic signed [WORD_W-1:0] tx, ty, tz;
  logic [RAD_W-1:0]     sum;
  logic [WORD_W-1:0]    len;
  logic [SCALE_W-1:0]   sc [0:2];
  logic signed [NW-1:0] nrm [0:8];
  logic signed [NW-1:0] rt;
  logic signed [ZW-1:0] ax, ay, az;

  logic                 accept;
  logic                 load_out;
  logic signed [WORD_W-1:0] e_sel;
  logic [WORD_W-1:0]    e_mag;
  logic [3:0]           n_idx;
  logic signed [NW-1:0] n_val;
  logic [WORD_W-1:0]    t_mag;
  logic [RAD_W-1:0]     rest;
  logic                 gimbal;
  logic signed [NW-1:0] cy, cx;

  logic                 mul_start;
  logic [WORD_W-1:0]    mul_a;
  logic [RAD_W-1:0]     prod;
  unit_sts_t            mul_sts;
  logic                 sqrt_start;
  logic [RAD_W-1:0]     sqrt_in;
  logic [RAD_W/2-1:0]   root;
  unit_sts_t            sqrt_sts;
  logic                 div_start;
  logic [FRAC_BITS:0]   quo;
  unit_sts_t            div_sts;
  logic                 cor_start;
  logic signed [ZW-1:0] cor_angle;
  unit_sts_t            cor_sts;

  assign in_stall = state != ST_IDLE;
  assign accept   = in_valid && !in_stall;
  assign load_out = state == ST_OUT && (!out_valid || !out_stall);

  assign e_sel  = row_q[{elem_cnt, 5'b0} +: WORD_W];
  assign e_mag  = e_sel[WORD_W-1] ? WORD_W'(-e_sel) : e_sel;
  assign n_idx  = {col_cnt, 1'b0} + {2'b00, col_cnt} + {2'b00, elem_cnt};
  assign n_val  = (len == '0) ? '0 :
                  (e_sel[WORD_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo}));
  assign t_mag  = nrm[2][NW-1] ? WORD_W'(-nrm[2]) : WORD_W'(nrm[2]);
  assign rest   = (RAD_W'(1) << (2 * FRAC_BITS)) - prod;
  assign gimbal = (nrm[2] >= ONE_Q) || (nrm[2] <= NEG_ONE);

  always_comb begin
    cy = nrm[1];
    cx = nrm[0];
    if (gimbal) begin
      cy = -nrm[6];
      cx = nrm[4];
    end else begin
      case (ang_cnt)
        ANG_X: begin
          cy = nrm[5];
          cx = nrm[8];
        end
        ANG_Y: begin
          cy = -nrm[2];
          cx = rt;
        end
        default: begin
          cy = nrm[1];
          cx = nrm[0];
        end
      endcase
    end
  end

  assign mul_start  = state == ST_SQ_GO || state == ST_TS_GO;
  assign mul_a      = (state == ST_TS_GO) ? t_mag : e_mag;
  assign sqrt_start = state == ST_RT_GO || state == ST_TR_GO;
  assign sqrt_in    = (state == ST_TR_GO) ? rest : sum;
  assign div_start  = state == ST_DV_GO;
  assign cor_start  = state == ST_CR_GO;

  amde_mul #(.W(WORD_W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .prod(prod), .sts(mul_sts)
  );

  amde_sqrt #(.W(RAD_W)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .rad_in(sqrt_in), .root(root), .sts(sqrt_sts)
  );

  amde_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(e_mag), .den(len), .quo(quo),
    .sts(div_sts)
  );

  amde_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .y_in(cy), .x_in(cx), .angle(cor_angle),
    .sts(cor_sts)
  );

  always_ff @(posedge clk) begin
    if (accept && column_index != 2'd3) begin
      basis[column_index] <= {col_z, col_y, col_x};
    end
    if (state == ST_LOAD) begin
      row_q <= basis[col_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      col_cnt   <= '0;
      elem_cnt  <= '0;
      ang_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && column_index == 2'd3) begin
            col_cnt  <= '0;
            elem_cnt <= '0;
            state    <= (col_w == '0) ? ST_OUT : ST_LOAD;
          end
        end
        ST_LOAD: begin
          elem_cnt <= '0;
          state    <= ST_SQ_GO;
        end
        ST_SQ_GO: state <= ST_SQ_WAIT;
        ST_SQ_WAIT: begin
          if (mul_sts.done) begin
            if (elem_cnt == 2'd2) begin
              elem_cnt <= '0;
              state    <= ST_RT_GO;
            end else begin
              elem_cnt <= elem_cnt + 1'b1;
              state    <= ST_SQ_GO;
            end
          end
        end
        ST_RT_GO: state <= ST_RT_WAIT;
        ST_RT_WAIT: begin
          if (sqrt_sts.done) begin
            state <= ST_DV_GO;
          end
        end
        ST_DV_GO: state <= ST_DV_WAIT;
        ST_DV_WAIT: begin
          if (div_sts.done) begin
            if (elem_cnt == 2'd2) begin
              elem_cnt <= '0;
              if (col_cnt == 2'd2) begin
                ang_cnt <= '0;
                state   <= gimbal ? ST_CR_GO : ST_TS_GO;
              end else begin
                col_cnt <= col_cnt + 1'b1;
                state   <= ST_LOAD;
              end
            end else begin
              elem_cnt <= elem_cnt + 1'b1;
              state    <= ST_DV_GO;
            end
          end
        end
        ST_TS_GO: state <= ST_TS_WAIT;
        ST_TS_WAIT: begin
          if (mul_sts.done) begin
            state <= ST_TR_GO;
          end
        end
        ST_TR_GO: state <= ST_TR_WAIT;
        ST_TR_WAIT: begin
          if (sqrt_sts.done) begin
            ang_cnt <= '0;
            state   <= ST_CR_GO;
          end
        end
        ST_CR_GO: state <= ST_CR_WAIT;
        ST_CR_WAIT: begin
          if (cor_sts.done) begin
            if (gimbal || ang_cnt == 2'd2) begin
              state <= ST_OUT;
            end else begin
              ang_cnt <= ang_cnt + 1'b1;
              state   <= ST_CR_GO;
            end
          end
        end
        ST_OUT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && column_index == 2'd3) begin
      tx  <= col_x;
      ty  <= col_y;
      tz  <= col_z;
      deg <= col_w == '0;
    end
    if (state == ST_LOAD) begin
      sum <= '0;
    end else if (state == ST_SQ_WAIT && mul_sts.done) begin
      sum <= sum + prod;
    end
    if (state == ST_RT_WAIT && sqrt_sts.done) begin
      len         <= root;
      sc[col_cnt] <= root[WORD_W-1] ? {SCALE_W{1'b1}} : root[SCALE_W-1:0];
    end
    if (state == ST_DV_WAIT && div_sts.done) begin
      nrm[n_idx] <= n_val;
    end
    if (state == ST_TR_WAIT && sqrt_sts.done) begin
      rt <= $signed({1'b0, root[FRAC_BITS:0]});
    end
    if (state == ST_CR_WAIT && cor_sts.done) begin
      if (gimbal) begin
        ax <= cor_angle;
        ay <= nrm[2][NW-1] ? HALF_PI_Q30 : -HALF_PI_Q30;
        az <= '0;
      end else begin
        case (ang_cnt)
          ANG_X:   ax <= cor_angle;
          ANG_Y:   ay <= cor_angle;
          default: az <= cor_angle;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      degenerate <= deg;
      trans_x    <= deg ? '0 : tx;
      trans_y    <= deg ? '0 : ty;
      trans_z    <= deg ? '0 : tz;
      scale_x    <= deg ? '0 : sc[0];
      scale_y    <= deg ? '0 : sc[1];
      scale_z    <= deg ? '0 : sc[2];
      angle_x    <= deg ? '0 : q30_to_q(ax);
      angle_y    <= deg ? '0 : (FRAC_BITS + 2)'(q30_to_q(ay));
      angle_z    <= deg ? '0 : q30_to_q(az);
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> scale_x == '0 && angle_x == '0 && trans_x == '0)
    else $error("degenerate result carries non-zero fields");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_sts.busy, sqrt_sts.busy, div_sts.busy, cor_sts.busy}))
    else $error("more than one arithmetic unit busy");

  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    mul_sts.done |-> state == ST_SQ_WAIT || state == ST_TS_WAIT)
    else $error("multiplier finished outside a wait state");

  a_cor_done: assert property (@(posedge clk) disable iff (rst)
    cor_sts.done |-> state == ST_CR_WAIT)
    else $error("arctangent finished outside its wait state");

endmodule
